>>> sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, codes, reset values and divider request types for the PWM
// sample encoder with soft start and soft stop ramps.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int RAMP_MAX   = 16;
    localparam int REPEAT_MAX = 16;

    localparam int SAMPLE_W   = 8;
    localparam int TICK_W     = 15;
    localparam int REPCFG_W   = 5;
    localparam int LENCFG_W   = 5;
    localparam int PERMILLE_W = 10;
    localparam int STEP_W     = 25;
    localparam int PHASE_W    = 2;
    localparam int CFG_W      = 25;
    localparam int CFG_IDX_W  = 3;

    localparam int IDX_W = $clog2(RAMP_MAX + 1);
    localparam int REP_W = $clog2(REPEAT_MAX + 1);

    // shared divider: widest dividend is sample * 1000
    localparam int DIV_DW = SAMPLE_W + PERMILLE_W;
    localparam int DIV_VW = TICK_W;

    // ramp entry product ramp_step * index, scaled down by 1000 through a
    // reciprocal multiply; products at or above the saturation point give
    // full scale, so only 25-bit products reach the multiplier
    localparam int PROD_W   = STEP_W + IDX_W;
    localparam int RECIP_W  = 26;
    localparam int RECIP_SH = 35;
    localparam logic [RECIP_W-1:0] RECIP_1000    = RECIP_W'(34359739);
    localparam logic [PROD_W-1:0]  RAMP_SAT_PROD = PROD_W'(32765000);

    localparam logic [PERMILLE_W-1:0] K_PERMILLE = PERMILLE_W'(1000);
    localparam logic [TICK_W-1:0]     RAMP_BASE  = TICK_W'(2);
    localparam logic [TICK_W-1:0]     TICK_MAX   = TICK_W'(32767);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PERMILLE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = CFG_IDX_W'(4);

    // reset values
    localparam logic [TICK_W-1:0]     RST_PERIOD   = TICK_W'(256);
    localparam logic [REPCFG_W-1:0]   RST_REPEATS  = REPCFG_W'(1);
    localparam logic [LENCFG_W-1:0]   RST_RAMP_LEN = LENCFG_W'(0);
    localparam logic [PERMILLE_W-1:0] RST_PERMILLE = PERMILLE_W'(1000);
    localparam logic [STEP_W-1:0]     RST_STEP     = STEP_W'(0);

    // symbol phase codes
    localparam logic [PHASE_W-1:0] PH_RISE = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_DATA = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_FALL = PHASE_W'(2);

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
    } t_div_rsp;

endpackage

>>> sv/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Restoring unsigned divider, one quotient bit per cycle. A start latches the
// operands; done pulses for one cycle with the quotient valid alongside.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_div_req i_req,
    output pse_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(pse_pkg::DIV_DW);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [pse_pkg::DIV_VW:0]    r_rem;
    logic [pse_pkg::DIV_DW-1:0]  r_quo;
    logic [pse_pkg::DIV_VW-1:0]  r_den;

    logic [pse_pkg::DIV_VW:0]    w_shift;
    logic                        w_ge;

    // dividend bits shift out of the top of r_quo as quotient bits shift in
    assign w_shift = {r_rem[pse_pkg::DIV_VW-1:0], r_quo[pse_pkg::DIV_DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(pse_pkg::DIV_DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quo <= {r_quo[pse_pkg::DIV_DW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> sv/pwm_sample_encoder_soft_ramp_core.sv
// ----------------------------------------------------------------------------
// pwm_sample_encoder_soft_ramp_core
// Turns 8-bit duty samples into PWM symbols (high ticks, low ticks), with a
// soft start ramp ahead of a first sample and a soft stop ramp after a last.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one sample word with its
//   first and last marks. Output channel (o_out_valid / i_out_stall) carries
//   one symbol word: high ticks, low ticks, phase, end_of_run on the last
//   symbol of the sample. A word moves when valid is high and stall is low.
//   Registers must be written through i_cfg_we / i_cfg_index / i_cfg_wdata
//   only while idle, unchecked by the block; they apply from the next sample.
// Timing
//   One sample at a time; o_in_stall stays high until its last symbol has
//   been loaded into the output register, and drops the cycle after. A plain
//   sample with one repeat runs S_PLAN then S_EMIT, which loads its symbol.
//   Each further data symbol is another S_EMIT; each ramp entry runs S_MUL,
//   S_RDIV, S_EMIT. A sample with a first or last mark sizes its ramp on the
//   shared bit-serial divider: one division when the duty reaches the
//   permille, two when it falls short, none at zero period.
// Reset and stall
//   Reset restores register defaults and drops any word in flight. A stall
//   at the output holds the current symbol; the sequencer waits at the next.
// ----------------------------------------------------------------------------
module pwm_sample_encoder_soft_ramp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pse_pkg::CFG_W-1:0]           i_cfg_wdata,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pse_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic                                i_is_first,
    input  logic                                i_is_final,
    // symbol output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pse_pkg::TICK_W-1:0]          o_high_ticks,
    output logic [pse_pkg::TICK_W-1:0]          o_low_ticks,
    output logic [pse_pkg::PHASE_W-1:0]         o_phase,
    output logic                                o_end_of_run
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TDIV = 7'b0000010,
        S_SDIV = 7'b0000100,
        S_PLAN = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_RDIV = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    localparam int IDX_W = pse_pkg::IDX_W;
    localparam int REP_W = pse_pkg::REP_W;
    localparam int TW    = pse_pkg::TICK_W;

    // configuration registers
    logic [TW-1:0]                   r_period;
    logic [pse_pkg::REPCFG_W-1:0]    r_repeats;
    logic [pse_pkg::LENCFG_W-1:0]    r_ramp_len;
    logic [pse_pkg::PERMILLE_W-1:0]  r_permille;
    logic [pse_pkg::STEP_W-1:0]      r_step;

    // sequencer
    t_state                          r_state,  n_state;
    logic [pse_pkg::SAMPLE_W-1:0]    r_sample, n_sample;
    logic                            r_first,  n_first;
    logic                            r_final,  n_final;
    logic [REP_W-1:0]                r_rep,    n_rep;
    logic [IDX_W-1:0]                r_size,   n_size;
    logic [IDX_W-1:0]                r_idx,    n_idx;
    logic [pse_pkg::PHASE_W-1:0]     r_phase,  n_phase;
    logic [TW-1:0]                   r_high,   n_high;
    logic [pse_pkg::PROD_W-1:0]      r_prod,   n_prod;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [TW-1:0]                   r_out_high,  n_out_high;
    logic [TW-1:0]                   r_out_low,   n_out_low;
    logic [pse_pkg::PHASE_W-1:0]     r_out_phase, n_out_phase;
    logic                            r_out_eor,   n_out_eor;

    pse_pkg::t_div_req               w_div_req;
    pse_pkg::t_div_rsp               w_div_rsp;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic [IDX_W-1:0]                w_len;
    logic [REP_W-1:0]                w_reps;
    logic [pse_pkg::STEP_W+pse_pkg::RECIP_W-1:0] w_rmul;
    logic [TW-1:0]                   w_hsat;
    logic [TW-1:0]                   w_low;
    logic                            w_t_reach;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= pse_pkg::RST_PERIOD;
            r_repeats  <= pse_pkg::RST_REPEATS;
            r_ramp_len <= pse_pkg::RST_RAMP_LEN;
            r_permille <= pse_pkg::RST_PERMILLE;
            r_step     <= pse_pkg::RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pse_pkg::CFG_PERIOD:   r_period   <= i_cfg_wdata[TW-1:0];
                pse_pkg::CFG_REPEATS:  r_repeats  <= i_cfg_wdata[pse_pkg::REPCFG_W-1:0];
                pse_pkg::CFG_RAMP_LEN: r_ramp_len <= i_cfg_wdata[pse_pkg::LENCFG_W-1:0];
                pse_pkg::CFG_PERMILLE: r_permille <= i_cfg_wdata[pse_pkg::PERMILLE_W-1:0];
                pse_pkg::CFG_STEP:     r_step     <= i_cfg_wdata[pse_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------------
    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if ({1'b0, r_ramp_len} > (pse_pkg::LENCFG_W + 1)'(pse_pkg::RAMP_MAX)) begin
            w_len = IDX_W'(pse_pkg::RAMP_MAX);
        end else begin
            w_len = IDX_W'(r_ramp_len);
        end
        if (r_repeats == '0) begin
            w_reps = REP_W'(1);
        end else if ({1'b0, r_repeats} > (pse_pkg::REPCFG_W + 1)'(pse_pkg::REPEAT_MAX)) begin
            w_reps = REP_W'(pse_pkg::REPEAT_MAX);
        end else begin
            w_reps = REP_W'(r_repeats);
        end
    end

    assign w_t_reach = (w_div_rsp.quot >= pse_pkg::DIV_DW'(r_permille));

    // ramp entry high ticks: product / 1000 + 2, saturated
    assign w_rmul = r_prod[pse_pkg::STEP_W-1:0] * pse_pkg::RECIP_1000;
    assign w_hsat = (r_prod >= pse_pkg::RAMP_SAT_PROD) ? pse_pkg::TICK_MAX
                  : w_rmul[pse_pkg::RECIP_SH +: TW] + pse_pkg::RAMP_BASE;

    assign w_low = (r_high >= r_period) ? '0 : (r_period - r_high);

    // divider operand select
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = pse_pkg::DIV_DW'(i_sample * pse_pkg::K_PERMILLE);
        w_div_req.divisor  = r_period;
        unique case (r_state)
            S_IDLE: begin
                // t = sample * 1000 / period
                w_div_req.start    = w_in_acc && (i_is_first || i_is_final)
                                   && (r_period != '0);
            end
            S_TDIV: begin
                // size = len * t / permille, only when t is below permille
                w_div_req.start    = w_div_rsp.done && !w_t_reach;
                w_div_req.dividend = pse_pkg::DIV_DW'(
                    w_len * w_div_rsp.quot[pse_pkg::PERMILLE_W-1:0]);
                w_div_req.divisor  = pse_pkg::DIV_VW'(r_permille);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_first     = r_first;
        n_final     = r_final;
        n_rep       = r_rep;
        n_size      = r_size;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_high      = r_high;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_high  = r_out_high;
        n_out_low   = r_out_low;
        n_out_phase = r_out_phase;
        n_out_eor   = r_out_eor;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sample = i_sample;
                    n_first  = i_is_first;
                    n_final  = i_is_final;
                    n_rep    = w_reps;
                    n_size   = (i_is_first || i_is_final) ? w_len : '0;
                    n_state  = w_div_req.start ? S_TDIV : S_PLAN;
                end
            end
            S_TDIV: begin
                if (w_div_rsp.done) begin
                    n_state = w_t_reach ? S_PLAN : S_SDIV;
                end
            end
            S_SDIV: begin
                if (w_div_rsp.done) begin
                    n_size  = w_div_rsp.quot[IDX_W-1:0];
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (r_first && (r_size != '0)) begin
                    n_phase = pse_pkg::PH_RISE;
                    n_idx   = '0;
                    n_state = S_MUL;
                end else begin
                    n_phase = pse_pkg::PH_DATA;
                    n_high  = TW'(r_sample);
                    n_state = S_EMIT;
                end
            end
            S_MUL: begin
                n_prod  = r_step * r_idx;
                n_state = S_RDIV;
            end
            S_RDIV: begin
                n_high  = w_hsat;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_high  = r_high;
                    n_out_low   = w_low;
                    n_out_phase = r_phase;
                    n_out_eor   = 1'b0;
                    case (r_phase)
                        pse_pkg::PH_RISE: begin
                            if (r_idx + 1'b1 == r_size) begin
                                n_phase = pse_pkg::PH_DATA;
                                n_high  = TW'(r_sample);
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        pse_pkg::PH_DATA: begin
                            if (r_rep == REP_W'(1)) begin
                                if (r_final && (r_size != '0)) begin
                                    n_phase = pse_pkg::PH_FALL;
                                    n_idx   = r_size - 1'b1;
                                    n_state = S_MUL;
                                end else begin
                                    n_out_eor = 1'b1;
                                    n_state   = S_IDLE;
                                end
                            end else begin
                                n_rep = r_rep - 1'b1;
                            end
                        end
                        default: begin
                            // falling ramp counts down to entry zero
                            if (r_idx == '0) begin
                                n_out_eor = 1'b1;
                                n_state   = S_IDLE;
                            end else begin
                                n_idx   = r_idx - 1'b1;
                                n_state = S_MUL;
                            end
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_first     <= n_first;
        r_final     <= n_final;
        r_rep       <= n_rep;
        r_size      <= n_size;
        r_idx       <= n_idx;
        r_phase     <= n_phase;
        r_high      <= n_high;
        r_prod      <= n_prod;
        r_out_high  <= n_out_high;
        r_out_low   <= n_out_low;
        r_out_phase <= n_out_phase;
        r_out_eor   <= n_out_eor;
    end

    assign o_out_valid  = r_out_valid;
    assign o_high_ticks = r_out_high;
    assign o_low_ticks  = r_out_low;
    assign o_phase      = r_out_phase;
    assign o_end_of_run = r_out_eor;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_TDIV || r_state == S_SDIV))
        else $error("divider result with no sequencer step waiting for it");

    a_ramp_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_idx < r_size))
        else $error("ramp entry index beyond ramp size");

    a_eor_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && n_out_eor) |=> (r_state == S_IDLE))
        else $error("end of run word loaded but sequencer kept going");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_high_ticks) && $stable(o_low_ticks)
             && $stable(o_phase) && $stable(o_end_of_run)))
        else $error("stalled output word changed");

    a_tick_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_high_ticks < r_period)
        |-> ((TW + 1)'(o_high_ticks) + (TW + 1)'(o_low_ticks) == (TW + 1)'(r_period)))
        else $error("high and low ticks do not add up to the period");

endmodule
